@@ sv/stp_pkg.sv @@
package stp_pkg;

    localparam int DEF_MAX_SEARCH  = 16;
    localparam int DEF_MAX_REPLACE = 16;
    localparam int DEF_COUNT_WIDTH = 32;

    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;
    localparam int LEN_W       = 5;
    localparam int OUT_COUNT_W = 32;
    localparam int REG_IDX_W   = 3;

    localparam logic [REG_IDX_W-1:0] REG_SEARCH_LOW   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SEARCH_HIGH  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SEARCH_LEN   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_REPLACE_LOW  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REPLACE_HIGH = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_REPLACE_LEN  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_IGNORE_CASE  = 3'd6;

    typedef struct packed {
        logic en;
        logic wr;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic                   load;
        logic                   close;
        logic [LEN_W-1:0]       len;
        logic [OUT_COUNT_W-1:0] count;
    } job_ctrl_t;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
        logic [7:0] r;
        r = c;
        if (ic && c >= 8'h41 && c <= 8'h5a)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

@@ sv/stp_cell.sv @@
module stp_cell (
    input  logic                clk,
    input  stp_pkg::cell_ctrl_t ctl,
    input  logic [7:0]          new_byte,
    input  logic [7:0]          right_byte,
    input  logic [7:0]          pat_byte,
    input  logic                ignore_case,
    output logic [7:0]          cur_byte,
    output logic                match
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    assign cur_byte  = ctl.wr ? new_byte : byte_reg;
    assign byte_next = ctl.shift ? right_byte : cur_byte;
    assign match     = stp_pkg::fold(cur_byte, ignore_case)
                       == stp_pkg::fold(pat_byte, ignore_case);

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            byte_reg <= byte_next;
        end
    end

endmodule

@@ sv/stp_emit.sv @@
module stp_emit #(
    parameter int JOB_DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  stp_pkg::job_ctrl_t                  ctl,
    input  logic [7:0]                          bytes_in [JOB_DEPTH],
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [7:0]                          out_byte,
    output logic                                byte_valid,
    output logic                                end_of_stream,
    output logic [stp_pkg::OUT_COUNT_W-1:0]     replacement_count,
    output logic                                run_last,
    output logic                                free
);

    logic                              active_reg, active_next;
    logic                              close_reg, close_next;
    logic [stp_pkg::LEN_W-1:0]         len_reg, len_next;
    logic [stp_pkg::OUT_COUNT_W-1:0]   count_reg, count_next;
    logic [7:0]                        bytes_reg  [JOB_DEPTH];
    logic [7:0]                        bytes_next [JOB_DEPTH];
    logic                              is_data;
    logic                              item_done;

    assign is_data           = len_reg != '0;
    assign out_valid         = active_reg;
    assign out_byte          = is_data ? bytes_reg[0] : 8'h00;
    assign byte_valid        = is_data;
    assign end_of_stream     = !is_data;
    assign replacement_count = is_data ? '0 : count_reg;
    assign run_last          = (len_reg == stp_pkg::LEN_W'(1) && !close_reg) || !is_data;
    assign item_done         = active_reg && !out_stall;
    assign free              = !active_reg || (item_done && run_last);

    always_comb
    begin
        active_next = active_reg;
        close_next  = close_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        bytes_next  = bytes_reg;
        if (ctl.load)
        begin
            active_next = 1'b1;
            close_next  = ctl.close;
            len_next    = ctl.len;
            count_next  = ctl.count;
            bytes_next  = bytes_in;
        end
        else if (item_done)
        begin
            // move the next word to the head
            for (int k = 0; k < JOB_DEPTH - 1; k++)
            begin
                bytes_next[k] = bytes_reg[k+1];
            end
            if (run_last)
            begin
                active_next = 1'b0;
            end
            if (is_data)
            begin
                len_next = len_reg - stp_pkg::LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            close_reg  <= 1'b0;
            len_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            close_reg  <= close_next;
            len_reg    <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        bytes_reg <= bytes_next;
    end

endmodule

@@ sv/stream_pattern_replace_top.sv @@
// Streaming byte search and replace. Bytes enter on in_byte with last_byte
// marking the end of a stream; every leftmost, non-overlapping occurrence of
// the pattern is replaced by the replacement, and after the last byte the
// held bytes are flushed and a closing word (byte_valid 0, end_of_stream 1)
// carries the saturating replacement count. The pattern sits in a row of
// MAX_SEARCH window cells that compare in parallel, so a byte is accepted
// every unstalled cycle while each byte yields at most one output word. A
// match yields as many words as the replacement length, and the final byte
// up to one more than the larger of MAX_SEARCH and MAX_REPLACE; the output
// register drains one word per unstalled cycle and input is stalled until
// the last of them leaves. A new pattern length is taken up only when the
// window is empty. Write configuration only while the block idles (unchecked).
module stream_pattern_replace_top #(
    parameter int MAX_SEARCH  = stp_pkg::DEF_MAX_SEARCH,
    parameter int MAX_REPLACE = stp_pkg::DEF_MAX_REPLACE,
    parameter int COUNT_WIDTH = stp_pkg::DEF_COUNT_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [stp_pkg::ADDR_W-1:0]        paddr,
    input  logic [stp_pkg::DATA_W-1:0]        pwdata,
    output logic [stp_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        in_byte,
    input  logic                              last_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        out_byte,
    output logic                              byte_valid,
    output logic                              end_of_stream,
    output logic [stp_pkg::OUT_COUNT_W-1:0]   replacement_count,
    output logic                              run_last
);

    localparam int FILL_W    = $clog2(MAX_SEARCH + 1);
    localparam int JOB_DEPTH = (MAX_SEARCH > MAX_REPLACE) ? MAX_SEARCH : MAX_REPLACE;
    localparam int LEN_W     = stp_pkg::LEN_W;

    logic [63:0]          search_low_reg, search_high_reg;
    logic [63:0]          replace_low_reg, replace_high_reg;
    logic [LEN_W-1:0]     search_len_reg, replace_len_reg;
    logic                 ignore_case_reg;
    logic [stp_pkg::REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [FILL_W-1:0]    active_reg, active_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next, total_inc;

    logic                 accept;
    logic                 emit_free;
    logic [FILL_W-1:0]    eff_search;
    logic [LEN_W-1:0]     eff_replace;
    logic [FILL_W-1:0]    act_len;
    logic [FILL_W-1:0]    fill_after;
    logic                 compared;
    logic                 all_eq;
    logic                 hit;
    logic                 do_shift;

    logic [127:0]         pat_vec, rep_vec;
    logic [7:0]           cur      [MAX_SEARCH];
    logic                 eq       [MAX_SEARCH];
    logic [7:0]           win_pad  [JOB_DEPTH];
    logic [7:0]           job_bytes[JOB_DEPTH];
    logic [63:0]          total_wide;
    stp_pkg::job_ctrl_t   job_ctl;

    // configuration port
    assign pready    = 1'b1;
    assign reg_idx   = paddr[stp_pkg::ADDR_W-1:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_low_reg   <= '0;
            search_high_reg  <= '0;
            search_len_reg   <= LEN_W'(1);
            replace_low_reg  <= '0;
            replace_high_reg <= '0;
            replace_len_reg  <= '0;
            ignore_case_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                stp_pkg::REG_SEARCH_LOW:   search_low_reg   <= pwdata;
                stp_pkg::REG_SEARCH_HIGH:  search_high_reg  <= pwdata;
                stp_pkg::REG_SEARCH_LEN:   search_len_reg   <= pwdata[LEN_W-1:0];
                stp_pkg::REG_REPLACE_LOW:  replace_low_reg  <= pwdata;
                stp_pkg::REG_REPLACE_HIGH: replace_high_reg <= pwdata;
                stp_pkg::REG_REPLACE_LEN:  replace_len_reg  <= pwdata[LEN_W-1:0];
                stp_pkg::REG_IGNORE_CASE:  ignore_case_reg  <= pwdata[0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            stp_pkg::REG_SEARCH_LOW:   prdata = search_low_reg;
            stp_pkg::REG_SEARCH_HIGH:  prdata = search_high_reg;
            stp_pkg::REG_SEARCH_LEN:   prdata = 64'(search_len_reg);
            stp_pkg::REG_REPLACE_LOW:  prdata = replace_low_reg;
            stp_pkg::REG_REPLACE_HIGH: prdata = replace_high_reg;
            stp_pkg::REG_REPLACE_LEN:  prdata = 64'(replace_len_reg);
            stp_pkg::REG_IGNORE_CASE:  prdata = 64'(ignore_case_reg);
            default:                   prdata = '0;
        endcase
    end

    // effective lengths
    always_comb
    begin
        if (search_len_reg == '0)
        begin
            eff_search = FILL_W'(1);
        end
        else if (search_len_reg > LEN_W'(MAX_SEARCH))
        begin
            eff_search = FILL_W'(MAX_SEARCH);
        end
        else
        begin
            eff_search = FILL_W'(search_len_reg);
        end
        if (replace_len_reg > LEN_W'(MAX_REPLACE))
        begin
            eff_replace = LEN_W'(MAX_REPLACE);
        end
        else
        begin
            eff_replace = replace_len_reg;
        end
    end

    assign accept     = in_valid && !in_stall;
    assign in_stall   = !emit_free;
    assign act_len    = (fill_reg == '0) ? eff_search : active_reg;
    assign fill_after = fill_reg + FILL_W'(1);
    assign compared   = fill_after == act_len;
    assign pat_vec    = {search_high_reg, search_low_reg};
    assign rep_vec    = {replace_high_reg, replace_low_reg};
    assign do_shift   = compared && !hit && !last_byte;

    // window cells
    for (genvar k = 0; k < MAX_SEARCH; k++)
    begin : g_cell
        stp_pkg::cell_ctrl_t cctl;
        logic [7:0]          right;

        assign cctl.en    = accept;
        assign cctl.wr    = fill_reg == FILL_W'(k);
        assign cctl.shift = do_shift;

        if (k < MAX_SEARCH - 1)
        begin : g_right
            assign right = cur[k+1];
        end
        else
        begin : g_end
            assign right = 8'h00;
        end

        stp_cell u_cell (
            .clk         (clk),
            .ctl         (cctl),
            .new_byte    (in_byte),
            .right_byte  (right),
            .pat_byte    (pat_vec[8*k +: 8]),
            .ignore_case (ignore_case_reg),
            .cur_byte    (cur[k]),
            .match       (eq[k])
        );
    end

    always_comb
    begin
        all_eq = 1'b1;
        for (int k = 0; k < MAX_SEARCH; k++)
        begin
            if (FILL_W'(k) < act_len && !eq[k])
            begin
                all_eq = 1'b0;
            end
        end
    end

    assign hit = compared && all_eq;

    // window and count state
    assign total_inc = (hit && total_reg != {COUNT_WIDTH{1'b1}})
                       ? total_reg + COUNT_WIDTH'(1) : total_reg;

    always_comb
    begin
        fill_next   = fill_reg;
        active_next = active_reg;
        total_next  = total_reg;
        if (accept)
        begin
            active_next = act_len;
            total_next  = last_byte ? '0 : total_inc;
            if (last_byte || hit)
            begin
                fill_next = '0;
            end
            else if (compared)
            begin
                fill_next = act_len - FILL_W'(1);
            end
            else
            begin
                fill_next = fill_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            active_reg <= FILL_W'(1);
            total_reg  <= '0;
        end
        else
        begin
            fill_reg   <= fill_next;
            active_reg <= active_next;
            total_reg  <= total_next;
        end
    end

    // words for the emitter
    for (genvar k = 0; k < JOB_DEPTH; k++)
    begin : g_job
        if (k < MAX_SEARCH)
        begin : g_win
            assign win_pad[k] = cur[k];
        end
        else
        begin : g_pad
            assign win_pad[k] = 8'h00;
        end
        assign job_bytes[k] = hit ? rep_vec[8*k +: 8] : win_pad[k];
    end

    assign total_wide = 64'(total_inc);

    always_comb
    begin
        if (hit)
        begin
            job_ctl.len = eff_replace;
        end
        else if (last_byte)
        begin
            job_ctl.len = LEN_W'(fill_after);
        end
        else if (compared)
        begin
            job_ctl.len = LEN_W'(1);
        end
        else
        begin
            job_ctl.len = '0;
        end
        job_ctl.close = last_byte;
        job_ctl.count = total_wide[stp_pkg::OUT_COUNT_W-1:0];
        job_ctl.load  = accept && (job_ctl.len != '0 || last_byte);
    end

    stp_emit #(
        .JOB_DEPTH (JOB_DEPTH)
    ) u_emit (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (job_ctl),
        .bytes_in          (job_bytes),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .out_byte          (out_byte),
        .byte_valid        (byte_valid),
        .end_of_stream     (end_of_stream),
        .replacement_count (replacement_count),
        .run_last          (run_last),
        .free              (emit_free)
    );

    a_fill_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != '0 |-> fill_reg < active_reg)
        else $error("window fill reached active length");

    a_close_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_stream |-> run_last && !byte_valid)
        else $error("closing word not last or carries data");

    a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> total_reg == '0 && fill_reg == '0)
        else $error("state not cleared after last byte");

    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !last_byte |=> total_reg >= $past(total_reg))
        else $error("match count went down mid-stream");

endmodule
